@@ design/rsort_pkg.sv @@
package rsort_pkg;

  localparam int MAX_RECORDS_DEF = 64;
  localparam int KEY_W           = 16;
  localparam int TAG_W           = 6;
  localparam int QUEUE_DEPTH     = 4;

  // one stored record
  typedef struct packed {
    logic [KEY_W-1:0] time_key;
    logic [KEY_W-1:0] pace_key;
    logic [TAG_W-1:0] tag;
  } rsort_rec_t;

  // queue entry from loader to sort engine
  typedef struct packed {
    rsort_rec_t rec;
    logic       last;
    logic       ksel;
  } rsort_entry_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_RDL,
    ST_RDR,
    ST_CMP,
    ST_EMIT_RD,
    ST_EMIT_CAP,
    ST_EMIT_HOLD
  } rsort_state_t;

  // sort key of a record: time key when ksel is set, else pace key
  function automatic logic [KEY_W-1:0] key_of(input rsort_rec_t r, input logic ksel);
    return ksel ? r.time_key : r.pace_key;
  endfunction

endpackage

@@ design/rsort_if.sv @@
interface rsort_in_if;
  import rsort_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] time_key;
  logic [KEY_W-1:0] pace_key;
  logic [TAG_W-1:0] record_tag;
  logic             last_record;

  modport source(output valid, time_key, pace_key, record_tag, last_record, input ready);
  modport sink(input valid, time_key, pace_key, record_tag, last_record, output ready);
endinterface

interface rsort_out_if;
  import rsort_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] out_time;
  logic [KEY_W-1:0] out_pace;
  logic [TAG_W-1:0] out_tag;
  logic             out_last;
  logic             records_dropped;

  modport source(output valid, out_time, out_pace, out_tag, out_last, records_dropped,
                 input ready);
  modport sink(input valid, out_time, out_pace, out_tag, out_last, records_dropped,
               output ready);
endinterface

@@ design/rsort_ram.sv @@
module rsort_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rsort_front.sv @@
module rsort_front
  import rsort_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  rsort_in_if.sink     records,
  input  logic         ksel,
  output rsort_entry_t q_entry,
  output logic         q_valid,
  input  logic         q_ready
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  rsort_entry_t     slots [QUEUE_DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    fill;
  logic             push;
  logic             pop;
  rsort_entry_t     new_entry;

  // pack the request with the key select in force when it arrives
  always_comb begin
    new_entry.rec.time_key = records.time_key;
    new_entry.rec.pace_key = records.pace_key;
    new_entry.rec.tag      = records.record_tag;
    new_entry.last         = records.last_record;
    new_entry.ksel         = ksel;
  end

  assign records.ready = (fill != CW'(QUEUE_DEPTH));
  assign push          = records.valid && records.ready;
  assign q_valid       = (fill != '0);
  assign pop           = q_valid && q_ready;
  assign q_entry       = slots[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= new_entry;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + PW'(1);
      if (pop)  rptr <= rptr + PW'(1);
      unique case ({push, pop})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ design/rsort_engine.sv @@
module rsort_engine
  import rsort_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  rsort_entry_t q_entry,
  input  logic         q_valid,
  output logic         q_ready,
  rsort_out_if.source  sorted
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int BW = CW + 1;
  localparam int RW = $bits(rsort_rec_t);

  rsort_state_t state, state_next;

  logic [CW-1:0] cnt;
  logic          ovf;
  logic          ksel;
  logic          sel;
  logic [BW-1:0] w;
  logic [BW-1:0] lo;
  logic [CW-1:0] li, le, ri, re, o, e;
  rsort_rec_t    lhead, rhead;
  logic          lhave, rhave, lpend, rpend;

  logic          out_valid;
  rsort_rec_t    out_rec;
  logic          out_last;
  logic          out_drop;

  logic [AW-1:0] raddr;
  logic [RW-1:0] rd0, rd1;
  rsort_rec_t    rdata;
  logic          we0, we1;
  logic [AW-1:0] waddr0;
  rsort_rec_t    wdata0;

  logic          pop;
  logic          room;
  logic [BW-1:0] n_ext;
  logic [BW-1:0] mid_raw, hi_raw, lo_step;
  logic [CW-1:0] mid, hi;
  logic          r_ok;
  rsort_rec_t    rval;
  logic          take_l, take_any;
  rsort_rec_t    wrec;
  logic          emit_last;

  assign rdata   = sel ? rsort_rec_t'(rd1) : rsort_rec_t'(rd0);
  assign pop     = q_valid && q_ready;
  assign room    = (cnt < CW'(MAX_RECORDS));
  assign n_ext   = BW'(cnt);

  // run bounds of the current merge block
  assign mid_raw = lo + w;
  assign hi_raw  = lo + (w << 1);
  assign lo_step = lo + (w << 1);
  assign mid     = (mid_raw > n_ext) ? cnt : mid_raw[CW-1:0];
  assign hi      = (hi_raw > n_ext) ? cnt : hi_raw[CW-1:0];

  // merge compare: left wins ties to keep load order
  assign r_ok     = rhave || rpend;
  assign rval     = rpend ? rdata : rhead;
  assign take_l   = lhave && (!r_ok || (key_of(lhead, ksel) <= key_of(rval, ksel)));
  assign take_any = lhave || r_ok;
  assign wrec     = take_l ? lhead : rval;
  assign emit_last = ((e + CW'(1)) == cnt);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:      if (pop && q_entry.last) state_next = ST_SETUP;
      ST_SETUP:     state_next = (w >= n_ext) ? ST_EMIT_RD : ST_RDL;
      ST_RDL:       state_next = ST_RDR;
      ST_RDR:       state_next = ST_CMP;
      ST_CMP:       state_next = take_any ? ST_RDL : ST_SETUP;
      ST_EMIT_RD:   state_next = ST_EMIT_CAP;
      ST_EMIT_CAP:  state_next = ST_EMIT_HOLD;
      ST_EMIT_HOLD: begin
        if (sorted.ready) state_next = out_last ? ST_LOAD : ST_EMIT_RD;
      end
      default:      state_next = ST_LOAD;
    endcase
  end

  // memory and queue control
  always_comb begin
    q_ready = 1'b0;
    raddr   = '0;
    we0     = 1'b0;
    we1     = 1'b0;
    waddr0  = o[AW-1:0];
    wdata0  = wrec;
    unique case (state)
      ST_LOAD: begin
        q_ready = 1'b1;
        we0     = pop && room;
        waddr0  = cnt[AW-1:0];
        wdata0  = q_entry.rec;
      end
      ST_RDL:     raddr = li[AW-1:0];
      ST_RDR:     raddr = ri[AW-1:0];
      ST_CMP: begin
        we0 = take_any && sel;
        we1 = take_any && !sel;
      end
      ST_EMIT_RD: raddr = e[AW-1:0];
      default: begin
      end
    endcase
  end

  // ping-pong buffers
  rsort_ram #(.WIDTH(RW), .DEPTH(MAX_RECORDS)) u_ram0 (
    .clk(clk), .we(we0), .waddr(waddr0), .wdata(wdata0), .raddr(raddr), .rdata(rd0)
  );

  rsort_ram #(.WIDTH(RW), .DEPTH(MAX_RECORDS)) u_ram1 (
    .clk(clk), .we(we1), .waddr(o[AW-1:0]), .wdata(wrec), .raddr(raddr), .rdata(rd1)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      cnt       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      lhave     <= 1'b0;
      rhave     <= 1'b0;
      lpend     <= 1'b0;
      rpend     <= 1'b0;
      sel       <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_LOAD: begin
          if (pop) begin
            if (room) cnt <= cnt + CW'(1);
            else      ovf <= 1'b1;
          end
          sel <= 1'b0;
        end
        ST_SETUP: begin
          lhave <= 1'b0;
          rhave <= 1'b0;
        end
        ST_RDL: lpend <= !lhave && (li < le);
        ST_RDR: begin
          if (lpend) lhave <= 1'b1;
          rpend <= !rhave && (ri < re);
        end
        ST_CMP: begin
          rpend <= 1'b0;
          if (take_l) begin
            lhave <= 1'b0;
            rhave <= r_ok;
          end else if (r_ok) begin
            rhave <= 1'b0;
          end
          if (!take_any && (lo_step >= n_ext)) sel <= ~sel;
        end
        ST_EMIT_CAP: out_valid <= 1'b1;
        ST_EMIT_HOLD: begin
          if (sorted.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              cnt <= '0;
              ovf <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // merge and emit datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: begin
        if (pop && q_entry.last) begin
          ksel <= q_entry.ksel;
          w    <= BW'(1);
          lo   <= '0;
        end
        e <= '0;
      end
      ST_SETUP: begin
        li <= lo[CW-1:0];
        le <= mid;
        ri <= mid;
        re <= hi;
        o  <= lo[CW-1:0];
      end
      ST_RDL: if (!lhave && (li < le)) li <= li + CW'(1);
      ST_RDR: begin
        if (lpend) lhead <= rdata;
        if (!rhave && (ri < re)) ri <= ri + CW'(1);
      end
      ST_CMP: begin
        if (take_any) begin
          o <= o + CW'(1);
          if (take_l) rhead <= rval;
        end else if (lo_step >= n_ext) begin
          w  <= w << 1;
          lo <= '0;
        end else begin
          lo <= lo_step;
        end
      end
      ST_EMIT_CAP: begin
        out_rec  <= rdata;
        out_last <= emit_last;
        out_drop <= emit_last && ovf;
      end
      ST_EMIT_HOLD: if (sorted.ready) e <= e + CW'(1);
      default: begin
      end
    endcase
  end

  assign sorted.valid           = out_valid;
  assign sorted.out_time        = out_rec.time_key;
  assign sorted.out_pace        = out_rec.pace_key;
  assign sorted.out_tag         = out_rec.tag;
  assign sorted.out_last        = out_last;
  assign sorted.records_dropped = out_drop;

endmodule

@@ design/stable_record_sort_by_key.sv @@
// Stable record sorter. Records enter on the records channel one per cycle while the
// four-entry queue has room; the sort engine drains it at one record a cycle, while it
// loads, into a MAX_RECORDS-deep buffer. A record flagged last closes the set (also when
// it is dropped for lack of room) and the engine runs a bottom-up merge sort between two
// single-port-read buffers: ceil(log2(n)) passes, each record through ST_RDL, ST_RDR and
// ST_CMP, ascending by time key (sort_key_select = 1) or pace key, ties in load order.
// Results leave through ST_EMIT_RD, ST_EMIT_CAP and ST_EMIT_HOLD, each held until taken;
// the last result carries out_last and, if any record was dropped, records_dropped. The
// sort key in force when the last record is accepted applies to the whole set. The merge
// rate is set by the one read port of the buffer that holds the runs.
module stable_record_sort_by_key
  import rsort_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  rsort_in_if.sink    records,
  rsort_out_if.source sorted
);

  logic         sort_key_select;
  rsort_entry_t q_entry;
  logic         q_valid;
  logic         q_ready;

  // key select register
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key_select <= 1'b1;
    end else if (cfg_we) begin
      sort_key_select <= cfg_wdata;
    end
  end

  rsort_front u_front (
    .clk(clk), .rst(rst), .records(records), .ksel(sort_key_select),
    .q_entry(q_entry), .q_valid(q_valid), .q_ready(q_ready)
  );

  rsort_engine #(.MAX_RECORDS(MAX_RECORDS)) u_engine (
    .clk(clk), .rst(rst), .q_entry(q_entry), .q_valid(q_valid), .q_ready(q_ready),
    .sorted(sorted)
  );

endmodule

@@ design/rsort_checker.sv @@
module rsort_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic out_drop,
  input logic [15:0] out_time
);

  // a pending request stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result request withdrawn");

  // time key and last flag steady while stalled
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_time) && $stable(out_last))
    else $error("stalled result changed");

  // drop flag only on the final result
  a_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_drop |-> out_last)
    else $error("drop flag on non-final result");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result after reset");

endmodule

bind stable_record_sort_by_key rsort_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(sorted.valid), .out_ready(sorted.ready),
  .out_last(sorted.out_last), .out_drop(sorted.records_dropped),
  .out_time(sorted.out_time)
);

@@ tb/sv/stable_record_sort_by_key_tb.sv @@
module stable_record_sort_by_key_tb;
  import rsort_pkg::*;

  localparam int CAP = MAX_RECORDS_DEF;

  typedef struct packed {
    logic [KEY_W-1:0] time_key;
    logic [KEY_W-1:0] pace_key;
    logic [TAG_W-1:0] tag;
    logic             last;
    logic             dropped;
  } sorted_rec_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  rsort_in_if  rec_ch();
  rsort_out_if out_ch();

  stable_record_sort_by_key uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .records   (rec_ch.sink),
    .sorted    (out_ch.source)
  );

  // predictor state
  rsort_rec_t  held_recs[$];
  logic        drop_seen;
  logic        key_sel;
  sorted_rec_t sorted_expect[$];
  int          err_count;
  int          hold_off;
  bit          sink_pause;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  // stable ascending sort of the held set, then queue the expected run
  task automatic predict_set();
    rsort_rec_t cur;
    logic [KEY_W-1:0] k;
    int j;
    for (int i = 1; i < held_recs.size(); i++) begin
      cur = held_recs[i];
      k = key_sel ? cur.time_key : cur.pace_key;
      j = i;
      while (j > 0 && (key_sel ? held_recs[j-1].time_key : held_recs[j-1].pace_key) > k) begin
        held_recs[j] = held_recs[j-1];
        j--;
      end
      held_recs[j] = cur;
    end
    for (int i = 0; i < held_recs.size(); i++) begin
      sorted_expect.push_back({held_recs[i].time_key, held_recs[i].pace_key, held_recs[i].tag,
                               i == held_recs.size() - 1,
                               (i == held_recs.size() - 1) && drop_seen});
    end
    held_recs.delete();
    drop_seen = 1'b0;
  endtask

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // send one request and update the prediction on acceptance
  task automatic send_rec(input logic [KEY_W-1:0] t, input logic [KEY_W-1:0] p,
                          input logic [TAG_W-1:0] g, input logic l, input int gap);
    rsort_rec_t r;
    repeat (gap) @(negedge clk);
    rec_ch.valid       = 1'b1;
    rec_ch.time_key    = t;
    rec_ch.pace_key    = p;
    rec_ch.record_tag  = g;
    rec_ch.last_record = l;
    do @(posedge clk); while (!rec_ch.ready);
    r.time_key = t;
    r.pace_key = p;
    r.tag = g;
    if (held_recs.size() < CAP) held_recs.push_back(r);
    else drop_seen = 1'b1;
    if (l) predict_set();
    @(negedge clk);
    rec_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (sorted_expect.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_key_sel(input logic v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    key_sel = v;
  endtask

  // random set; keys from a narrow range make ties common
  task automatic send_set(input int n, input bit narrow, input bit busy);
    logic [KEY_W-1:0] t, p;
    for (int i = 0; i < n; i++) begin
      t = narrow ? KEY_W'($urandom_range(0, 3)) : KEY_W'($urandom);
      p = narrow ? KEY_W'($urandom_range(0, 3)) : KEY_W'($urandom);
      send_rec(t, p, TAG_W'($urandom), i == n - 1, busy ? 0 : short_gap());
    end
  endtask

  // output ready, random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (sink_pause) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    sorted_rec_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (sorted_expect.size() == 0) begin
        $error("unexpected result tag %0d", out_ch.out_tag);
        err_count++;
      end else begin
        e = sorted_expect.pop_front();
        if (out_ch.out_time !== e.time_key) begin
          $error("out_time expected %0d actual %0d", e.time_key, out_ch.out_time);
          err_count++;
        end
        if (out_ch.out_pace !== e.pace_key) begin
          $error("out_pace expected %0d actual %0d", e.pace_key, out_ch.out_pace);
          err_count++;
        end
        if (out_ch.out_tag !== e.tag) begin
          $error("out_tag expected %0d actual %0d", e.tag, out_ch.out_tag);
          err_count++;
        end
        if (out_ch.out_last !== e.last) begin
          $error("out_last expected %0d actual %0d", e.last, out_ch.out_last);
          err_count++;
        end
        if (out_ch.records_dropped !== e.dropped) begin
          $error("records_dropped expected %0d actual %0d", e.dropped,
                 out_ch.records_dropped);
          err_count++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_rec('1, '0, '1, 1'b1, 0);
    send_rec('0, '1, '0, 1'b0, 0);
    send_rec('1, '1, 6'h2a, 1'b0, 1);
    send_rec(16'h5555, 16'haaaa, 6'h15, 1'b0, 0);
    send_rec(16'haaaa, 16'h5555, 6'h3f, 1'b1, 0);
    wait_idle();
    write_key_sel(1'b0);
    send_rec(16'h0007, 16'h0003, 6'd1, 1'b0, 0);
    send_rec(16'h0001, 16'h0003, 6'd2, 1'b0, 0);
    send_rec(16'h0009, 16'h0001, 6'd3, 1'b0, 0);
    send_rec(16'h0004, 16'hffff, 6'd4, 1'b1, 0);
    wait_idle();
  endtask

  task automatic test_ties();
    write_key_sel(1'b1);
    send_set(12, 1'b1, 1'b0);
    wait_idle();
  endtask

  // key change during loading applies only from the closing record
  task automatic test_key_change_mid_set();
    send_rec(16'd3, 16'd1, 6'd10, 1'b0, 0);
    send_rec(16'd1, 16'd3, 6'd11, 1'b0, 0);
    wait_idle();
    write_key_sel(1'b0);
    send_rec(16'd2, 16'd2, 6'd12, 1'b1, 0);
    wait_idle();
  endtask

  // full store, drops, closing record itself dropped
  task automatic test_overflow();
    write_key_sel(1'b1);
    send_set(CAP + 3, 1'b0, 1'b1);
    wait_idle();
  endtask

  // output held off while input keeps coming
  task automatic test_backpressure();
    @(negedge clk);
    hold_off <= 400;
    send_set(6, 1'b0, 1'b1);
    send_set(5, 1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    sink_pause = 1'b1;
    while (sent < 20) begin
      int n;
      n = $urandom_range(1, 8);
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        write_key_sel(1'($urandom_range(0, 1)));
      end
      send_set(n, $urandom_range(0, 1), 1'b0);
      sent += n;
    end
    sink_pause = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    rec_ch.valid = 1'b0;
    rec_ch.time_key = '0;
    rec_ch.pace_key = '0;
    rec_ch.record_tag = '0;
    rec_ch.last_record = 1'b0;
    out_ch.ready = 1'b0;
    drop_seen = 1'b0;
    key_sel = 1'b1;
    err_count = 0;
    hold_off = 0;
    sink_pause = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_ties();
    test_key_change_mid_set();
    test_overflow();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (50) @(negedge clk);
    if (err_count == 0 && sorted_expect.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/rsort_pkg.sv
design/rsort_if.sv
design/rsort_ram.sv
design/rsort_front.sv
design/rsort_engine.sv
design/stable_record_sort_by_key.sv
design/rsort_checker.sv
tb/sv/stable_record_sort_by_key_tb.sv
